>>> hdl/ps2mc_pkg.sv
// Shared types and constants for the PS/2 mouse cursor tracker.
package ps2mc_pkg;

    // Width of the screen size registers and of the cursor fields
    localparam int COORD_W = 12;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;

    // Reset values of the screen size registers
    localparam int SCREEN_WIDTH_RESET  = 640;
    localparam int SCREEN_HEIGHT_RESET = 480;

    // Bit positions inside the flags byte
    localparam int FLAG_LEFT    = 0;
    localparam int FLAG_RIGHT   = 1;
    localparam int FLAG_MIDDLE  = 2;
    localparam int FLAG_ALWAYS1 = 3;
    localparam int FLAG_X_SIGN  = 4;
    localparam int FLAG_Y_SIGN  = 5;
    localparam int FLAG_X_OVF   = 6;
    localparam int FLAG_Y_OVF   = 7;

    // Signed movement: sign bit from the flags byte plus the data byte
    localparam int MOVE_W = 9;

    // One byte from the mouse
    typedef struct packed {
        logic [7:0] data_byte;
        logic       settling;
    } byte_word_t;

    // One cursor update
    typedef struct packed {
        logic [COORD_W-1:0] cursor_x;
        logic [COORD_W-1:0] cursor_y;
        logic               left_button;
        logic               right_button;
        logic               middle_button;
    } cursor_word_t;

endpackage

>>> hdl/ps2_mouse_cursor_tracker_core.sv
// Top level of the PS/2 mouse cursor tracker: packet framing, cursor state, output buffering.
//
// Takes one mouse byte per cycle and groups non-settling bytes into three-byte
// packets (flags, X, Y). A packet with an overflow bit set or the always-one bit
// clear is dropped whole; framing never resynchronizes. Each good packet moves the
// cursor (X added, Y subtracted), clamps it to 0..screen size, and yields one registered
// cursor word from its third byte. Bytes are taken every cycle while byte_stall is low;
// it rises only when both the output register and the skid stage behind it hold words
// that the receiver has not taken. The user writes the screen size registers through
// cfg_we / cfg_index / cfg_data only while no packet is in flight; the block does not
// enforce this. COORD_BITS limits the cursor range to 0..2^COORD_BITS-1 (at most 12 bits).
module ps2_mouse_cursor_tracker_core #(
    parameter int COORD_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                byte_valid,
    output logic                                byte_stall,
    input  ps2mc_pkg::byte_word_t               byte_word,
    output logic                                cursor_valid,
    input  logic                                cursor_stall,
    output ps2mc_pkg::cursor_word_t             cursor_word,
    input  logic                                cfg_we,
    input  logic [ps2mc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ps2mc_pkg::COORD_W-1:0]       cfg_data
);
    import ps2mc_pkg::*;

    // Stored cursor width: never more than the output field carries
    localparam int POS_W = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam logic [COORD_W-1:0] POS_LIM = COORD_W'((1 << POS_W) - 1);
    localparam logic [COORD_W-1:0] HALF_W  = COORD_W'(SCREEN_WIDTH_RESET / 2);
    localparam logic [COORD_W-1:0] HALF_H  = COORD_W'(SCREEN_HEIGHT_RESET / 2);
    localparam logic [COORD_W-1:0] RST_X12 = (HALF_W > POS_LIM) ? POS_LIM : HALF_W;
    localparam logic [COORD_W-1:0] RST_Y12 = (HALF_H > POS_LIM) ? POS_LIM : HALF_H;
    localparam logic [POS_W-1:0]   RST_X   = RST_X12[POS_W-1:0];
    localparam logic [POS_W-1:0]   RST_Y   = RST_Y12[POS_W-1:0];

    typedef enum logic [1:0] {
        PHASE_FLAGS = 2'd0,
        PHASE_X     = 2'd1,
        PHASE_Y     = 2'd2
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic               discard_reg, discard_next;
    logic [7:0]         flag_reg, flag_next;
    logic [7:0]         xbyte_reg, xbyte_next;
    logic [POS_W-1:0]   pos_x_reg, pos_x_next;
    logic [POS_W-1:0]   pos_y_reg, pos_y_next;
    logic [COORD_W-1:0] width_reg, height_reg;
    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    cursor_word_t       out_word_reg, out_word_next;
    cursor_word_t       skid_word_reg, skid_word_next;

    logic               byte_fire;
    logic               cursor_fire;
    logic               res_valid;
    cursor_word_t       res_word;
    logic [COORD_W-1:0] bound_x12, bound_y12;
    logic [POS_W-1:0]   bound_x, bound_y;
    logic [POS_W-1:0]   new_x, new_y;
    logic [MOVE_W-1:0]  move_x, move_y;

    assign byte_stall   = skid_valid_reg;
    assign byte_fire    = byte_valid & ~byte_stall & ~byte_word.settling;
    assign cursor_valid = out_valid_reg;
    assign cursor_word  = out_word_reg;
    assign cursor_fire  = out_valid_reg & ~cursor_stall;

    // Limit the clamp bounds to the cursor range
    always_comb
    begin
        bound_x12 = (width_reg > POS_LIM) ? POS_LIM : width_reg;
        bound_y12 = (height_reg > POS_LIM) ? POS_LIM : height_reg;
        bound_x   = bound_x12[POS_W-1:0];
        bound_y   = bound_y12[POS_W-1:0];
        move_x    = {flag_reg[FLAG_X_SIGN], xbyte_reg};
        move_y    = {flag_reg[FLAG_Y_SIGN], byte_word.data_byte};
    end

    ps2mc_axis #(
        .POS_W (POS_W)
    ) u_axis_x (
        .pos      (pos_x_reg),
        .move     (move_x),
        .invert   (1'b0),
        .bound    (bound_x),
        .pos_next (new_x)
    );

    ps2mc_axis #(
        .POS_W (POS_W)
    ) u_axis_y (
        .pos      (pos_y_reg),
        .move     (move_y),
        .invert   (1'b1),
        .bound    (bound_y),
        .pos_next (new_y)
    );

    // Advance the packet phase and update the cursor on the third byte
    always_comb
    begin
        phase_next   = phase_reg;
        discard_next = discard_reg;
        flag_next    = flag_reg;
        xbyte_next   = xbyte_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        res_valid    = 1'b0;
        if (byte_fire)
        begin
            unique case (phase_reg)
                PHASE_X:
                begin
                    xbyte_next = byte_word.data_byte;
                    phase_next = PHASE_Y;
                end
                PHASE_Y:
                begin
                    phase_next   = PHASE_FLAGS;
                    discard_next = 1'b0;
                    if (!discard_reg)
                    begin
                        pos_x_next = new_x;
                        pos_y_next = new_y;
                        res_valid  = 1'b1;
                    end
                end
                default:
                begin
                    flag_next  = byte_word.data_byte;
                    phase_next = PHASE_X;
                    if (byte_word.data_byte[FLAG_X_OVF] || byte_word.data_byte[FLAG_Y_OVF] ||
                        !byte_word.data_byte[FLAG_ALWAYS1])
                    begin
                        discard_next = 1'b1;
                    end
                end
            endcase
        end
    end

    // Build the cursor word from the updated position and the flags byte
    always_comb
    begin
        res_word.cursor_x      = COORD_W'(new_x);
        res_word.cursor_y      = COORD_W'(new_y);
        res_word.left_button   = flag_reg[FLAG_LEFT];
        res_word.right_button  = flag_reg[FLAG_RIGHT];
        res_word.middle_button = flag_reg[FLAG_MIDDLE];
    end

    // Route results through the output register and its skid stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (skid_valid_reg)
        begin
            if (cursor_fire)
            begin
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (out_valid_reg && !cursor_fire)
        begin
            if (res_valid)
            begin
                skid_word_next  = res_word;
                skid_valid_next = 1'b1;
            end
        end
        else
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_word_next = res_word;
            end
        end
    end

    // Hold packet state, cursor and valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PHASE_FLAGS;
            discard_reg    <= 1'b0;
            flag_reg       <= '0;
            xbyte_reg      <= '0;
            pos_x_reg      <= RST_X;
            pos_y_reg      <= RST_Y;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            discard_reg    <= discard_next;
            flag_reg       <= flag_next;
            xbyte_reg      <= xbyte_next;
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold output and skid words
    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    // Write the screen size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= COORD_W'(SCREEN_WIDTH_RESET);
            height_reg <= COORD_W'(SCREEN_HEIGHT_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                CFG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

endmodule

>>> hdl/ps2mc_axis.sv
// One cursor axis: add or subtract a signed movement and clamp to 0..bound.
module ps2mc_axis #(
    parameter int POS_W = 12
) (
    input  logic [POS_W-1:0]            pos,
    input  logic [ps2mc_pkg::MOVE_W-1:0] move,
    input  logic                        invert,
    input  logic [POS_W-1:0]            bound,
    output logic [POS_W-1:0]            pos_next
);
    import ps2mc_pkg::*;

    // Two extra bits cover the full movement range on either side when POS_W is at least 8
    localparam int SUM_W = POS_W + 2;

    logic signed [SUM_W-1:0] pos_s;
    logic signed [SUM_W-1:0] move_s;
    logic signed [SUM_W-1:0] bound_s;
    logic signed [SUM_W-1:0] sum;

    // Extend operands and apply the movement
    always_comb
    begin
        pos_s   = signed'(SUM_W'(pos));
        bound_s = signed'(SUM_W'(bound));
        move_s  = SUM_W'(signed'(move));
        sum     = invert ? (pos_s - move_s) : (pos_s + move_s);
    end

    // Clamp inclusively to the bound
    always_comb
    begin
        if (sum[SUM_W-1])
        begin
            pos_next = '0;
        end
        else if (sum > bound_s)
        begin
            pos_next = bound;
        end
        else
        begin
            pos_next = sum[POS_W-1:0];
        end
    end

endmodule

>>> hdl/ps2mc_checker.sv
// Port-level checks for the PS/2 mouse cursor tracker, bound to the top level.
module ps2mc_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    byte_valid,
    input logic                    byte_stall,
    input ps2mc_pkg::byte_word_t   byte_word,
    input logic                    cursor_valid,
    input logic                    cursor_stall,
    input ps2mc_pkg::cursor_word_t cursor_word
);
    import ps2mc_pkg::*;

    // A stalled cursor word stays put
    a_cursor_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_valid && cursor_stall |=> cursor_valid && $stable(cursor_word))
        else $error("cursor word changed while stalled");

    // Byte input stalls only while a cursor word waits
    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> cursor_valid)
        else $error("byte input stalled with no cursor word pending");

    // Byte input starts stalling only after the cursor side stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(byte_stall) |-> $past(cursor_stall))
        else $error("byte stall rose without a cursor stall");

    // A fresh cursor word comes from a byte taken the cycle before
    a_word_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cursor_valid) |-> $past(byte_valid && !byte_stall && !byte_word.settling))
        else $error("cursor word appeared without an accepted byte");

endmodule

bind ps2_mouse_cursor_tracker_core ps2mc_checker u_ps2mc_checker (.*);

>>> sim/tb_ps2_mouse_cursor_tracker_core.sv
// Self-checking testbench for the PS/2 mouse cursor tracker core.
module tb_ps2_mouse_cursor_tracker_core;

    timeunit 1ns;
    timeprecision 1ps;

    import ps2mc_pkg::*;

    localparam int COORD_BITS      = 12;
    localparam int N_PHASES        = 10;
    localparam int BYTES_PER_PHASE = 123;
    localparam int DRAIN_SLACK     = 8;
    localparam int MAX_REPORTS     = 10;

    // Tracks the packet framing and cursor, holds the cursor words still owed
    class cursor_scoreboard;
        cursor_word_t        owed_q[$];
        logic [1:0]          pkt_phase;
        bit                  drop_pkt;
        logic [7:0]          flags;
        logic [7:0]          x_byte;
        int                  cur_x;
        int                  cur_y;
        logic [COORD_W-1:0]  width_reg;
        logic [COORD_W-1:0]  height_reg;
        int                  errors;
        int                  words_checked;
        int                  bytes_taken;
        int                  bytes_settled;
        int                  pkts_dropped;
        int                  reg_writes;

        function new();
            pkt_phase     = 2'd0;
            drop_pkt      = 1'b0;
            flags         = 8'h00;
            x_byte        = 8'h00;
            width_reg     = COORD_W'(SCREEN_WIDTH_RESET);
            height_reg    = COORD_W'(SCREEN_HEIGHT_RESET);
            cur_x         = clamp(SCREEN_WIDTH_RESET / 2, coord_max());
            cur_y         = clamp(SCREEN_HEIGHT_RESET / 2, coord_max());
            errors        = 0;
            words_checked = 0;
            bytes_taken   = 0;
            bytes_settled = 0;
            pkts_dropped  = 0;
            reg_writes    = 0;
        endfunction

        function int coord_max();
            return (1 << COORD_BITS) - 1;
        endfunction

        function int clamp(int v, int hi);
            if (v > hi)
                return hi;
            if (v < 0)
                return 0;
            return v;
        endfunction

        function int bound_of(logic [COORD_W-1:0] r);
            return (int'(r) > coord_max()) ? coord_max() : int'(r);
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [COORD_W-1:0] val);
            reg_writes++;
            if (idx == CFG_SCREEN_WIDTH)
                width_reg = val;
            else if (idx == CFG_SCREEN_HEIGHT)
                height_reg = val;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Advance the framing by one accepted byte; owe a word on a good packet's last byte
        function void note_byte(byte_word_t w);
            int           dx;
            int           dy;
            cursor_word_t c;
            if (w.settling)
            begin
                bytes_settled++;
                return;
            end
            bytes_taken++;
            if (pkt_phase == 2'd1)
            begin
                x_byte    = w.data_byte;
                pkt_phase = 2'd2;
                return;
            end
            if (pkt_phase != 2'd2)
            begin
                flags     = w.data_byte;
                pkt_phase = 2'd1;
                if (flags[FLAG_X_OVF] || flags[FLAG_Y_OVF] || !flags[FLAG_ALWAYS1])
                    drop_pkt = 1'b1;
                return;
            end
            pkt_phase = 2'd0;
            if (drop_pkt)
            begin
                drop_pkt = 1'b0;
                pkts_dropped++;
                return;
            end
            dx = flags[FLAG_X_SIGN] ? int'(x_byte) - 256 : int'(x_byte);
            dy = flags[FLAG_Y_SIGN] ? int'(w.data_byte) - 256 : int'(w.data_byte);
            cur_x = clamp(cur_x + dx, bound_of(width_reg));
            cur_y = clamp(cur_y - dy, bound_of(height_reg));
            c.cursor_x      = COORD_W'(cur_x);
            c.cursor_y      = COORD_W'(cur_y);
            c.left_button   = flags[FLAG_LEFT];
            c.right_button  = flags[FLAG_RIGHT];
            c.middle_button = flags[FLAG_MIDDLE];
            owed_q.push_back(c);
        endfunction

        // Compare an accepted cursor word with the oldest one owed
        function void check_cursor(cursor_word_t got);
            cursor_word_t want;
            bit           bad;
            words_checked++;
            if (owed_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected cursor word x=%0d y=%0d btn=%b%b%b", $realtime,
                             got.cursor_x, got.cursor_y, got.middle_button,
                             got.right_button, got.left_button);
                return;
            end
            want = owed_q.pop_front();
            bad  = (got.cursor_x !== want.cursor_x) || (got.cursor_y !== want.cursor_y) ||
                   (got.left_button !== want.left_button) ||
                   (got.right_button !== want.right_button) ||
                   (got.middle_button !== want.middle_button);
            if (bad)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"%0t: cursor mismatch: expected x=%0d y=%0d btn(m,r,l)=%b%b%b,",
                              " got x=%0d y=%0d btn(m,r,l)=%b%b%b"},
                             $realtime, want.cursor_x, want.cursor_y, want.middle_button,
                             want.right_button, want.left_button, got.cursor_x, got.cursor_y,
                             got.middle_button, got.right_button, got.left_button);
            end
        endfunction
    endclass

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   byte_valid   = 1'b0;
    logic                   byte_stall;
    byte_word_t             byte_word    = '0;
    logic                   cursor_valid;
    logic                   cursor_stall = 1'b0;
    cursor_word_t           cursor_word;
    logic                   cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = CFG_SCREEN_WIDTH;
    logic [COORD_W-1:0]     cfg_data     = '0;

    cursor_scoreboard sb = new();
    int sender_mode   = 0;
    int receiver_mode = 0;

    ps2_mouse_cursor_tracker_core #(
        .COORD_BITS(COORD_BITS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_word    (byte_word),
        .cursor_valid (cursor_valid),
        .cursor_stall (cursor_stall),
        .cursor_word  (cursor_word),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle cycles for one word: none, fully random, or mostly none with rare long gaps
    function automatic int draw_wait(int mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 13);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
        endcase
    endfunction

    // Offer one word after a random gap and hold it until taken
    task automatic send_word(input byte_word_t w);
        int gap;
        gap = draw_wait(sender_mode);
        repeat (gap)
        begin
            @(negedge clk);
            byte_valid <= 1'b0;
        end
        @(negedge clk);
        byte_valid <= 1'b1;
        byte_word  <= w;
        do
            @(posedge clk);
        while (byte_stall);
        sb.note_byte(w);
    endtask

    // Send a mouse byte, now and then preceded by a byte dropped for settling
    task automatic send_mouse_byte(input logic [7:0] b);
        if ($urandom_range(0, 11) == 0)
            send_word('{data_byte: 8'($urandom_range(0, 255)), settling: 1'b1});
        send_word('{data_byte: b, settling: 1'b0});
    endtask

    // Send a well-formed packet; drift biases the movement signs (+1, 0, -1)
    task automatic send_good_packet(input int drift_x, input int drift_y);
        logic [7:0] f;
        f = 8'($urandom_range(0, 255));
        f[FLAG_ALWAYS1] = 1'b1;
        f[FLAG_X_OVF]   = 1'b0;
        f[FLAG_Y_OVF]   = 1'b0;
        if (drift_x != 0 && $urandom_range(0, 4) != 0)
            f[FLAG_X_SIGN] = (drift_x < 0);
        // y is subtracted, so a negative movement pushes the cursor up in value
        if (drift_y != 0 && $urandom_range(0, 4) != 0)
            f[FLAG_Y_SIGN] = (drift_y > 0);
        send_mouse_byte(f);
        send_mouse_byte(8'($urandom_range(0, 255)));
        send_mouse_byte(8'($urandom_range(0, 255)));
    endtask

    // Drop valid and hold until every owed word has come and the core has gone quiet
    task automatic hold_until_drained();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [COORD_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    // Receiver: stall a random number of cycles per word, then take it and check it
    initial
    begin
        int n;
        forever
        begin
            n = draw_wait(receiver_mode);
            repeat (n)
            begin
                @(negedge clk);
                cursor_stall <= 1'b1;
            end
            @(negedge clk);
            cursor_stall <= 1'b0;
            do
                @(posedge clk);
            while (!cursor_valid);
            sb.check_cursor(cursor_word);
        end
    end

    initial
    begin
        #5_000_000;
        $display("timeout: %0d words still owed", sb.pending());
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus
    initial
    begin
        int                 k;
        int                 goal;
        int                 dx_drift;
        int                 dy_drift;
        int                 r;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: settling drop, buttons, extreme moves, each discard reason, clamps
        send_word('{data_byte: 8'hFF, settling: 1'b1});
        send_word('{data_byte: 8'h0F, settling: 1'b0});
        send_word('{data_byte: 8'hFF, settling: 1'b0});
        send_word('{data_byte: 8'h00, settling: 1'b0});
        send_word('{data_byte: 8'h38, settling: 1'b0});
        send_word('{data_byte: 8'h00, settling: 1'b0});
        send_word('{data_byte: 8'h00, settling: 1'b0});
        send_word('{data_byte: 8'h48, settling: 1'b0});
        send_word('{data_byte: 8'h01, settling: 1'b0});
        send_word('{data_byte: 8'h01, settling: 1'b0});
        send_word('{data_byte: 8'h88, settling: 1'b0});
        send_word('{data_byte: 8'h7F, settling: 1'b0});
        send_word('{data_byte: 8'h7F, settling: 1'b0});
        send_word('{data_byte: 8'h07, settling: 1'b0});
        send_word('{data_byte: 8'h7F, settling: 1'b0});
        send_word('{data_byte: 8'h7F, settling: 1'b0});
        send_word('{data_byte: 8'h0E, settling: 1'b0});
        send_word('{data_byte: 8'hAA, settling: 1'b1});
        send_word('{data_byte: 8'hFF, settling: 1'b0});
        send_word('{data_byte: 8'h00, settling: 1'b1});
        send_word('{data_byte: 8'h80, settling: 1'b0});
        send_word('{data_byte: 8'h19, settling: 1'b0});
        send_word('{data_byte: 8'h00, settling: 1'b0});
        send_word('{data_byte: 8'h7F, settling: 1'b0});

        for (k = 0; k < N_PHASES; k++)
        begin
            hold_until_drained();
            case (k)
                0:
                begin
                    w = 12'd0;
                    h = 12'd0;
                end
                1:
                begin
                    w = 12'd4095;
                    h = 12'd4095;
                end
                2:
                begin
                    w = 12'd100;
                    h = 12'd50;
                end
                3:
                begin
                    w = 12'd4095;
                    h = 12'd0;
                end
                4:
                begin
                    w = 12'd1;
                    h = 12'd4095;
                end
                5:
                begin
                    w = 12'd640;
                    h = 12'd480;
                end
                default:
                begin
                    w = 12'($urandom_range(0, 4095));
                    h = 12'($urandom_range(0, 4095));
                end
            endcase
            write_reg(CFG_SCREEN_WIDTH, w);
            write_reg(CFG_SCREEN_HEIGHT, h);
            @(negedge clk);
            cfg_we <= 1'b0;

            sender_mode   = (k == 0) ? 0 : $urandom_range(0, 2);
            receiver_mode = (k == 1) ? 0 : $urandom_range(0, 2);
            // push the cursor to the far corner before the bounds are lowered
            dx_drift      = (k == 1) ? 1 : $urandom_range(0, 2) - 1;
            dy_drift      = (k == 1) ? 1 : $urandom_range(0, 2) - 1;
            goal          = sb.bytes_taken + BYTES_PER_PHASE;

            while (sb.bytes_taken < goal)
            begin
                r = $urandom_range(0, 99);
                if (r < 84)
                    send_good_packet(dx_drift, dy_drift);
                else if (r < 95)
                    repeat (3) send_mouse_byte(8'($urandom_range(0, 255)));
                else
                    send_mouse_byte(8'($urandom_range(0, 255)));
                // in phase 4, hold off mid-phase until the receiver has caught up
                if (k == 4 && sb.bytes_taken >= goal - BYTES_PER_PHASE / 2 &&
                    sb.bytes_taken < goal - BYTES_PER_PHASE / 2 + 3)
                    hold_until_drained();
            end

            // finish any open packet so the next register write lands between packets
            while (sb.pkt_phase != 2'd0)
                send_mouse_byte(8'($urandom_range(0, 255)));
        end

        hold_until_drained();
        if (sb.pending() != 0)
            sb.errors++;

        $display("Sent %0d mouse bytes plus %0d settling bytes over %0d register writes.",
                 sb.bytes_taken, sb.bytes_settled, sb.reg_writes);
        $display("Checked %0d cursor words; %0d packets were discarded by the flag checks.",
                 sb.words_checked, sb.pkts_dropped);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
